### hdl/mmh_pkg.sv
// Shared constants, datapath op codes and controller/datapath interface types.
package mmh_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned LEN_W   = 31;
    localparam int unsigned ADDR_W  = 3;

    localparam logic [WORD_W-1:0] MIX_MUL = 32'h5bd1_e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    // register word index (paddr[2])
    localparam logic REG_SEED = 1'b0;

    // datapath operations
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_K1   = 3'd2;
    localparam logic [2:0] OP_K2   = 3'd3;
    localparam logic [2:0] OP_HMIX = 3'd4;
    localparam logic [2:0] OP_TAIL = 3'd5;
    localparam logic [2:0] OP_FIN  = 3'd6;

    typedef struct packed {
        logic [2:0] op;
    } mmh_cmd_t;

    typedef struct packed {
        logic in_full;   // request carries a full word
        logic in_empty;  // request carries no bytes
        logic in_last;   // request ends the key
        logic last;      // loaded request ends the key
    } mmh_stat_t;

endpackage

### hdl/mmh_ctrl.sv
// Sequencer for the shared multiplier and the handshakes.
module mmh_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  mmh_pkg::mmh_stat_t stat,
    output mmh_pkg::mmh_cmd_t  cmd
);
    import mmh_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_K1   = 3'd1;
    localparam logic [2:0] S_K2   = 3'd2;
    localparam logic [2:0] S_HMIX = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       fin_go;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && (state_reg == S_IDLE);
    // result slot must be free before the finalizer overwrites it
    assign fin_go    = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op = OP_LOAD;
                    if (stat.in_full)
                        state_next = S_K1;
                    else if (!stat.in_empty)
                        state_next = S_TAIL;
                    else if (stat.in_last)
                        state_next = S_FIN;
                    else
                        state_next = S_IDLE;
                end
            end
            S_K1:
            begin
                cmd.op     = OP_K1;
                state_next = S_K2;
            end
            S_K2:
            begin
                cmd.op     = OP_K2;
                state_next = S_HMIX;
            end
            S_HMIX:
            begin
                cmd.op     = OP_HMIX;
                state_next = stat.last ? S_FIN : S_IDLE;
            end
            S_TAIL:
            begin
                cmd.op     = OP_TAIL;
                state_next = stat.last ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    cmd.op     = OP_FIN;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (fin_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/mmh_dp.sv
// Hash datapath: running hash, mix register and one shared constant multiplier.
module mmh_dp
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mmh_pkg::mmh_cmd_t          cmd,
    output mmh_pkg::mmh_stat_t         stat,
    input  logic [mmh_pkg::WORD_W-1:0] seed,
    input  logic [mmh_pkg::WORD_W-1:0] data_word,
    input  logic [mmh_pkg::CNT_W-1:0]  byte_count,
    input  logic                       first_item,
    input  logic                       last_item,
    input  logic [mmh_pkg::LEN_W-1:0]  total_len,
    output logic [mmh_pkg::WORD_W-1:0] hash_value
);
    import mmh_pkg::*;

    logic [WORD_W-1:0] h_reg;
    logic [WORD_W-1:0] h_next;
    logic [WORD_W-1:0] k_reg;
    logic [WORD_W-1:0] k_next;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [WORD_W-1:0] hash_reg;
    logic [WORD_W-1:0] hash_next;
    logic              last_reg;
    logic              last_next;
    logic [WORD_W-1:0] word_mask;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] prod;

    // bytes above byte_count are dropped at load; 4..7 keep the full word
    always_comb
    begin
        case (byte_count)
            3'd1:    word_mask = 32'h0000_00ff;
            3'd2:    word_mask = 32'h0000_ffff;
            3'd3:    word_mask = 32'h00ff_ffff;
            default: word_mask = 32'hffff_ffff;
        endcase
    end

    assign stat.in_full  = byte_count[CNT_W-1];
    assign stat.in_empty = (byte_count == '0);
    assign stat.in_last  = last_item;
    assign stat.last     = last_reg;

    always_comb
    begin
        case (cmd.op)
            OP_K1:   mul_a = word_reg;
            OP_K2:   mul_a = k_reg ^ (k_reg >> MIX_SHIFT);
            OP_HMIX: mul_a = h_reg;
            OP_TAIL: mul_a = h_reg ^ word_reg;
            OP_FIN:  mul_a = h_reg ^ (h_reg >> FIN_SHIFT_A);
            default: mul_a = h_reg;
        endcase
    end

    // low half of the product is all that is kept
    assign prod = mul_a * MIX_MUL;

    always_comb
    begin
        h_next    = h_reg;
        k_next    = k_reg;
        word_next = word_reg;
        hash_next = hash_reg;
        last_next = last_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                word_next = data_word & word_mask;
                last_next = last_item;
                if (first_item)
                    h_next = seed ^ {1'b0, total_len};
            end
            OP_K1:   k_next    = prod;
            OP_K2:   k_next    = prod;
            OP_HMIX: h_next    = prod ^ k_reg;
            OP_TAIL: h_next    = prod;
            OP_FIN:  hash_next = prod ^ (prod >> FIN_SHIFT_B);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg    <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            h_reg    <= h_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        word_reg <= word_next;
        hash_reg <= hash_next;
    end

    assign hash_value = hash_reg;

endmodule

### hdl/murmurhash2_stream.sv
// Streaming 32-bit MurmurHash2 top level: config register, controller, datapath.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  config   | psel/penable/pwrite/pready | paddr, pwdata, prdata (seed at 0x0)
//  input    | in_valid / in_ready      | data_word, byte_count, first_item,
//           |                          | last_item, total_len
//  output   | out_valid / out_ready    | hash_value
//
// One multiplier serves all steps. A full word is accepted, then passes two
// key multiplies and a hash multiply; a tail word is accepted and then takes
// the tail multiply, an empty word only the accept; a last request adds the
// finalizer multiply. The result sits in an output register; the next request
// is taken while it waits, and only the finalizer stalls until the output
// register is free. rst_n clears the seed and the running hash to zero.
module murmurhash2_stream
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mmh_pkg::ADDR_W-1:0] paddr,
    input  logic [mmh_pkg::WORD_W-1:0] pwdata,
    output logic [mmh_pkg::WORD_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [mmh_pkg::WORD_W-1:0] data_word,
    input  logic [mmh_pkg::CNT_W-1:0]  byte_count,
    input  logic                       first_item,
    input  logic                       last_item,
    input  logic [mmh_pkg::LEN_W-1:0]  total_len,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mmh_pkg::WORD_W-1:0] hash_value
);
    import mmh_pkg::*;

    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] seed_next;
    logic              seed_sel;
    mmh_cmd_t          cmd;
    mmh_stat_t         stat;

    assign pready   = 1'b1;
    assign seed_sel = (paddr[ADDR_W-1] == REG_SEED);
    assign prdata   = seed_sel ? seed_reg : '0;

    always_comb
    begin
        seed_next = seed_reg;
        if (psel && penable && pwrite && seed_sel)
            seed_next = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else
            seed_reg <= seed_next;
    end

    mmh_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mmh_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .seed       (seed_reg),
        .data_word  (data_word),
        .byte_count (byte_count),
        .first_item (first_item),
        .last_item  (last_item),
        .total_len  (total_len),
        .hash_value (hash_value)
    );

endmodule
